// ===== rtl/pycb_pkg.sv =====
// Shared types, codes, constants and the micro-program for the pitch/yaw camera basis block.
// Used by the controller, the datapath, the top level and the checker.
package pycb_pkg;

    localparam int PITCH_LIMIT_DEF = 16194;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

    // configuration register indexes
    localparam logic [1:0] CFG_UP_X = 2'd0;
    localparam logic [1:0] CFG_UP_Y = 2'd1;
    localparam logic [1:0] CFG_UP_Z = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_ANGLE    = 4'd1,
        OP_CINIT    = 4'd2,
        OP_CSTEP    = 4'd3,
        OP_CSTORE   = 4'd4,
        OP_MUL      = 4'd5,
        OP_ACC_LD   = 4'd6,
        OP_ACC_SUB  = 4'd7,
        OP_ACC_ADD  = 4'd8,
        OP_WR       = 4'd9,
        OP_SQ_INIT  = 4'd10,
        OP_SQ_STEP  = 4'd11,
        OP_DV_INIT  = 4'd12,
        OP_DV_STEP  = 4'd13,
        OP_DV_STORE = 4'd14,
        OP_OUT      = 4'd15
    } t_op;

    // CORDIC angle select
    localparam logic [4:0] CS_PITCH = 5'd0;
    localparam logic [4:0] CS_YAW   = 5'd1;

    // multiplier operand pairs
    localparam logic [4:0] MS_CYCP = 5'd0;
    localparam logic [4:0] MS_SYCP = 5'd1;
    localparam logic [4:0] MS_D1W2 = 5'd2;
    localparam logic [4:0] MS_D2W1 = 5'd3;
    localparam logic [4:0] MS_D2W0 = 5'd4;
    localparam logic [4:0] MS_D0W2 = 5'd5;
    localparam logic [4:0] MS_D0W1 = 5'd6;
    localparam logic [4:0] MS_D1W0 = 5'd7;
    localparam logic [4:0] MS_R1D2 = 5'd8;
    localparam logic [4:0] MS_R2D1 = 5'd9;
    localparam logic [4:0] MS_R2D0 = 5'd10;
    localparam logic [4:0] MS_R0D2 = 5'd11;
    localparam logic [4:0] MS_R0D1 = 5'd12;
    localparam logic [4:0] MS_R1D0 = 5'd13;
    localparam logic [4:0] MS_SQ0  = 5'd14;
    localparam logic [4:0] MS_SQ1  = 5'd15;
    localparam logic [4:0] MS_SQ2  = 5'd16;

    // write-back destinations
    localparam logic [4:0] WD_DX = 5'd0;
    localparam logic [4:0] WD_DZ = 5'd1;
    localparam logic [4:0] WD_V0 = 5'd2;
    localparam logic [4:0] WD_V1 = 5'd3;
    localparam logic [4:0] WD_V2 = 5'd4;

    // vector component select and normalised destinations
    localparam logic [4:0] VC_0  = 5'd0;
    localparam logic [4:0] VC_1  = 5'd1;
    localparam logic [4:0] VC_2  = 5'd2;
    localparam logic [4:0] ND_R0 = 5'd0;
    localparam logic [4:0] ND_R1 = 5'd1;
    localparam logic [4:0] ND_R2 = 5'd2;
    localparam logic [4:0] ND_U0 = 5'd3;
    localparam logic [4:0] ND_U1 = 5'd4;
    localparam logic [4:0] ND_U2 = 5'd5;

    localparam logic [4:0] L_ONE   = 5'd0;
    localparam logic [4:0] L_CORD  = 5'd16;
    localparam logic [4:0] L_SQRT  = 5'd31;
    localparam logic [4:0] L_DIV   = 5'd15;

    localparam logic [6:0] PROG_LAST = 7'd73;

    typedef struct packed {
        t_op        op;
        logic [4:0] sel;
        logic [4:0] last;
    } t_uop;

    typedef struct packed {
        t_op        op;
        logic [4:0] sel;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic acc_zero;
    } t_stat;

    function automatic t_uop mk(t_op o, logic [4:0] s, logic [4:0] l);
        t_uop u;
        u.op   = o;
        u.sel  = s;
        u.last = l;
        return u;
    endfunction

    function automatic t_uop prog(logic [6:0] pc);
        t_uop u;
        case (pc)
            7'd0:  u = mk(OP_CINIT,    CS_PITCH, L_ONE);
            7'd1:  u = mk(OP_CSTEP,    CS_PITCH, L_CORD);
            7'd2:  u = mk(OP_CSTORE,   CS_PITCH, L_ONE);
            7'd3:  u = mk(OP_CINIT,    CS_YAW,   L_ONE);
            7'd4:  u = mk(OP_CSTEP,    CS_YAW,   L_CORD);
            7'd5:  u = mk(OP_CSTORE,   CS_YAW,   L_ONE);
            7'd6:  u = mk(OP_MUL,      MS_CYCP,  L_ONE);
            7'd7:  u = mk(OP_WR,       WD_DX,    L_ONE);
            7'd8:  u = mk(OP_MUL,      MS_SYCP,  L_ONE);
            7'd9:  u = mk(OP_WR,       WD_DZ,    L_ONE);
            7'd10: u = mk(OP_MUL,      MS_D1W2,  L_ONE);
            7'd11: u = mk(OP_ACC_LD,   WD_V0,    L_ONE);
            7'd12: u = mk(OP_MUL,      MS_D2W1,  L_ONE);
            7'd13: u = mk(OP_ACC_SUB,  WD_V0,    L_ONE);
            7'd14: u = mk(OP_WR,       WD_V0,    L_ONE);
            7'd15: u = mk(OP_MUL,      MS_D2W0,  L_ONE);
            7'd16: u = mk(OP_ACC_LD,   WD_V1,    L_ONE);
            7'd17: u = mk(OP_MUL,      MS_D0W2,  L_ONE);
            7'd18: u = mk(OP_ACC_SUB,  WD_V1,    L_ONE);
            7'd19: u = mk(OP_WR,       WD_V1,    L_ONE);
            7'd20: u = mk(OP_MUL,      MS_D0W1,  L_ONE);
            7'd21: u = mk(OP_ACC_LD,   WD_V2,    L_ONE);
            7'd22: u = mk(OP_MUL,      MS_D1W0,  L_ONE);
            7'd23: u = mk(OP_ACC_SUB,  WD_V2,    L_ONE);
            7'd24: u = mk(OP_WR,       WD_V2,    L_ONE);
            7'd25: u = mk(OP_MUL,      MS_SQ0,   L_ONE);
            7'd26: u = mk(OP_ACC_LD,   VC_0,     L_ONE);
            7'd27: u = mk(OP_MUL,      MS_SQ1,   L_ONE);
            7'd28: u = mk(OP_ACC_ADD,  VC_1,     L_ONE);
            7'd29: u = mk(OP_MUL,      MS_SQ2,   L_ONE);
            7'd30: u = mk(OP_ACC_ADD,  VC_2,     L_ONE);
            7'd31: u = mk(OP_SQ_INIT,  VC_0,     L_ONE);
            7'd32: u = mk(OP_SQ_STEP,  VC_0,     L_SQRT);
            7'd33: u = mk(OP_DV_INIT,  VC_0,     L_ONE);
            7'd34: u = mk(OP_DV_STEP,  VC_0,     L_DIV);
            7'd35: u = mk(OP_DV_STORE, ND_R0,    L_ONE);
            7'd36: u = mk(OP_DV_INIT,  VC_1,     L_ONE);
            7'd37: u = mk(OP_DV_STEP,  VC_1,     L_DIV);
            7'd38: u = mk(OP_DV_STORE, ND_R1,    L_ONE);
            7'd39: u = mk(OP_DV_INIT,  VC_2,     L_ONE);
            7'd40: u = mk(OP_DV_STEP,  VC_2,     L_DIV);
            7'd41: u = mk(OP_DV_STORE, ND_R2,    L_ONE);
            7'd42: u = mk(OP_MUL,      MS_R1D2,  L_ONE);
            7'd43: u = mk(OP_ACC_LD,   WD_V0,    L_ONE);
            7'd44: u = mk(OP_MUL,      MS_R2D1,  L_ONE);
            7'd45: u = mk(OP_ACC_SUB,  WD_V0,    L_ONE);
            7'd46: u = mk(OP_WR,       WD_V0,    L_ONE);
            7'd47: u = mk(OP_MUL,      MS_R2D0,  L_ONE);
            7'd48: u = mk(OP_ACC_LD,   WD_V1,    L_ONE);
            7'd49: u = mk(OP_MUL,      MS_R0D2,  L_ONE);
            7'd50: u = mk(OP_ACC_SUB,  WD_V1,    L_ONE);
            7'd51: u = mk(OP_WR,       WD_V1,    L_ONE);
            7'd52: u = mk(OP_MUL,      MS_R0D1,  L_ONE);
            7'd53: u = mk(OP_ACC_LD,   WD_V2,    L_ONE);
            7'd54: u = mk(OP_MUL,      MS_R1D0,  L_ONE);
            7'd55: u = mk(OP_ACC_SUB,  WD_V2,    L_ONE);
            7'd56: u = mk(OP_WR,       WD_V2,    L_ONE);
            7'd57: u = mk(OP_MUL,      MS_SQ0,   L_ONE);
            7'd58: u = mk(OP_ACC_LD,   VC_0,     L_ONE);
            7'd59: u = mk(OP_MUL,      MS_SQ1,   L_ONE);
            7'd60: u = mk(OP_ACC_ADD,  VC_1,     L_ONE);
            7'd61: u = mk(OP_MUL,      MS_SQ2,   L_ONE);
            7'd62: u = mk(OP_ACC_ADD,  VC_2,     L_ONE);
            7'd63: u = mk(OP_SQ_INIT,  VC_0,     L_ONE);
            7'd64: u = mk(OP_SQ_STEP,  VC_0,     L_SQRT);
            7'd65: u = mk(OP_DV_INIT,  VC_0,     L_ONE);
            7'd66: u = mk(OP_DV_STEP,  VC_0,     L_DIV);
            7'd67: u = mk(OP_DV_STORE, ND_U0,    L_ONE);
            7'd68: u = mk(OP_DV_INIT,  VC_1,     L_ONE);
            7'd69: u = mk(OP_DV_STEP,  VC_1,     L_DIV);
            7'd70: u = mk(OP_DV_STORE, ND_U1,    L_ONE);
            7'd71: u = mk(OP_DV_INIT,  VC_2,     L_ONE);
            7'd72: u = mk(OP_DV_STEP,  VC_2,     L_DIV);
            7'd73: u = mk(OP_DV_STORE, ND_U2,    L_ONE);
            default: u = mk(OP_NOP,    VC_0,     L_ONE);
        endcase
        return u;
    endfunction

    // arctangent of 2^-i in Q.8 binary angle units
    function automatic logic signed [24:0] atan_val(logic [4:0] i);
        logic signed [24:0] v;
        case (i)
            5'd0:  v = 25'sd2097152;
            5'd1:  v = 25'sd1238021;
            5'd2:  v = 25'sd654136;
            5'd3:  v = 25'sd332050;
            5'd4:  v = 25'sd166669;
            5'd5:  v = 25'sd83416;
            5'd6:  v = 25'sd41718;
            5'd7:  v = 25'sd20860;
            5'd8:  v = 25'sd10430;
            5'd9:  v = 25'sd5215;
            5'd10: v = 25'sd2608;
            5'd11: v = 25'sd1304;
            5'd12: v = 25'sd652;
            5'd13: v = 25'sd326;
            5'd14: v = 25'sd163;
            5'd15: v = 25'sd81;
            5'd16: v = 25'sd41;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/pitch_yaw_camera_basis_unit.sv =====
// Top level of the pitch/yaw camera basis block: joins sequencer and datapath.
// Depends on pycb_pkg, pycb_ctrl and pycb_datapath.
//
// Use:
//   Input channel i_valid/o_ready carries one item: i_action (0 add deltas,
//   1 set absolutely), i_pitch_angle and i_yaw_angle as binary angles.
//   Output channel o_valid/i_ready carries the direction, right and camera up
//   vectors (Q2.14), the clamped pitch, the wrapped yaw and the degenerate flag.
//   Configuration channel i_cfg_valid/o_cfg_ready writes the world up vector;
//   it is always ready, and the user must write it only while the block is idle
//   (the block itself does not enforce this). One item is worked on at a time:
//   the micro-program runs two 17-step CORDIC passes, two 32-step square roots
//   and six 16-step divisions on one shared datapath.
//   A degenerate item skips the remaining steps and finishes early.
//   The result sits in an output register; the next item is taken as soon as
//   the sequencer is back in idle, even if the result has not been taken.
//   A stalled receiver holds the result, and a finished item waits for it.
//   Reset clears pitch and yaw to zero and the world up vector to (0, 1, 0).
module pitch_yaw_camera_basis_unit
    import pycb_pkg::*;
#(
    parameter int PITCH_LIMIT = PITCH_LIMIT_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_cam_up_x,
    output logic signed [15:0] o_cam_up_y,
    output logic signed [15:0] o_cam_up_z,
    output logic signed [14:0] o_pitch_now,
    output logic signed [15:0] o_yaw_now,
    output logic               o_degenerate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    pycb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pycb_datapath #(
        .PITCH_LIMIT (PITCH_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_pitch_angle (i_pitch_angle),
        .i_yaw_angle   (i_yaw_angle),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_dir_z       (o_dir_z),
        .o_right_x     (o_right_x),
        .o_right_y     (o_right_y),
        .o_right_z     (o_right_z),
        .o_cam_up_x    (o_cam_up_x),
        .o_cam_up_y    (o_cam_up_y),
        .o_cam_up_z    (o_cam_up_z),
        .o_pitch_now   (o_pitch_now),
        .o_yaw_now     (o_yaw_now),
        .o_degenerate  (o_degenerate)
    );

endmodule

// ===== rtl/pycb_ctrl.sv =====
// Sequencer for the camera basis block: steps through the micro-program in pycb_pkg.
// Drives datapath commands and both handshakes; depends on pycb_pkg.
module pycb_ctrl
    import pycb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_pc, n_pc;
    logic [4:0] r_step, n_step;
    logic       r_ovalid, n_ovalid;
    t_uop       uop;

    assign uop         = prog(r_pc);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_step   = r_step;
        n_ovalid = r_ovalid;
        o_cmd    = '{op: OP_NOP, sel: VC_0, step: 5'd0};
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ANGLE;
                    n_state  = S_RUN;
                    n_pc     = 7'd0;
                    n_step   = 5'd0;
                end
            end
            S_RUN: begin
                o_cmd = '{op: uop.op, sel: uop.sel, step: r_step};
                // zero norm: skip the rest, right and up stay cleared
                if (uop.op == OP_SQ_INIT && i_stat.acc_zero) begin
                    n_state = S_OUT;
                end else if (r_step == uop.last) begin
                    n_step = 5'd0;
                    if (r_pc == PROG_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_pc = r_pc + 7'd1;
                    end
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= 7'd0;
            r_step   <= 5'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== rtl/pycb_datapath.sv =====
// Datapath of the camera basis block: angle state, shared CORDIC, multiplier with
// accumulator, bit-pair square root, restoring divider and output register. Uses pycb_pkg.
module pycb_datapath
    import pycb_pkg::*;
#(
    parameter int PITCH_LIMIT = PITCH_LIMIT_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_action,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_cam_up_x,
    output logic signed [15:0] o_cam_up_y,
    output logic signed [15:0] o_cam_up_z,
    output logic signed [14:0] o_pitch_now,
    output logic signed [15:0] o_yaw_now,
    output logic               o_degenerate
);

    localparam logic signed [16:0] LIM = 17'(PITCH_LIMIT);

    logic signed [14:0] r_pitch;
    logic        [15:0] r_yaw;
    logic signed [15:0] r_up [3];
    logic signed [31:0] r_cx, r_cy;
    logic signed [24:0] r_cz;
    logic               r_flip;
    logic signed [31:0] r_cosp, r_siny, r_cosy;
    logic signed [15:0] r_d [3];
    logic signed [63:0] r_prod, r_acc;
    logic signed [31:0] r_v [3];
    logic        [63:0] r_sqn, r_sqr;
    logic        [31:0] r_rem;
    logic        [15:0] r_num, r_q;
    logic               r_neg;
    logic signed [15:0] r_r [3];
    logic signed [15:0] r_u [3];
    logic               r_degen;

    logic signed [15:0] r_o_d [3];
    logic signed [15:0] r_o_r [3];
    logic signed [15:0] r_o_u [3];
    logic signed [14:0] r_o_pitch;
    logic        [15:0] r_o_yaw;
    logic               r_o_degen;

    function automatic logic signed [15:0] clamp16(logic signed [63:0] v);
        logic signed [15:0] o;
        if (v > 64'sd16384) begin
            o = ONE_Q14;
        end else if (v < -64'sd16384) begin
            o = -ONE_Q14;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

    function automatic logic signed [31:0] sx16(logic signed [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // angle update
    logic signed [16:0] p_sum, p_clamped;
    always_comb begin
        p_sum = i_action ? {i_pitch_angle[15], i_pitch_angle}
                         : {{2{r_pitch[14]}}, r_pitch} + {i_pitch_angle[15], i_pitch_angle};
        if (p_sum > LIM) begin
            p_clamped = LIM;
        end else if (p_sum < -LIM) begin
            p_clamped = -LIM;
        end else begin
            p_clamped = p_sum;
        end
    end

    // CORDIC fold
    logic signed [16:0] c_ang, c_fold;
    logic               c_flip;
    always_comb begin
        c_ang  = (i_cmd.sel == CS_YAW) ? {r_yaw[15], r_yaw} : {{2{r_pitch[14]}}, r_pitch};
        c_fold = c_ang;
        c_flip = 1'b0;
        if (c_ang > 17'sd16384) begin
            c_fold = c_ang - 17'sd32768;
            c_flip = 1'b1;
        end else if (c_ang < -17'sd16384) begin
            c_fold = c_ang + 17'sd32768;
            c_flip = 1'b1;
        end
    end

    logic signed [31:0] c_xs, c_ys, c_xf, c_yf;
    logic signed [24:0] c_at;
    logic signed [32:0] dy_sum;
    assign c_xs   = r_cx >>> i_cmd.step;
    assign c_ys   = r_cy >>> i_cmd.step;
    assign c_at   = atan_val(i_cmd.step);
    assign c_xf   = r_flip ? -r_cx : r_cx;
    assign c_yf   = r_flip ? -r_cy : r_cy;
    assign dy_sum = {c_yf[31], c_yf} + 33'sd8192;

    // multiplier operands
    logic signed [31:0] m_a, m_b;
    always_comb begin
        m_a = r_cosy;
        m_b = r_cosp;
        case (i_cmd.sel)
            MS_CYCP: begin m_a = r_cosy;       m_b = r_cosp;       end
            MS_SYCP: begin m_a = r_siny;       m_b = r_cosp;       end
            MS_D1W2: begin m_a = sx16(r_d[1]); m_b = sx16(r_up[2]); end
            MS_D2W1: begin m_a = sx16(r_d[2]); m_b = sx16(r_up[1]); end
            MS_D2W0: begin m_a = sx16(r_d[2]); m_b = sx16(r_up[0]); end
            MS_D0W2: begin m_a = sx16(r_d[0]); m_b = sx16(r_up[2]); end
            MS_D0W1: begin m_a = sx16(r_d[0]); m_b = sx16(r_up[1]); end
            MS_D1W0: begin m_a = sx16(r_d[1]); m_b = sx16(r_up[0]); end
            MS_R1D2: begin m_a = sx16(r_r[1]); m_b = sx16(r_d[2]);  end
            MS_R2D1: begin m_a = sx16(r_r[2]); m_b = sx16(r_d[1]);  end
            MS_R2D0: begin m_a = sx16(r_r[2]); m_b = sx16(r_d[0]);  end
            MS_R0D2: begin m_a = sx16(r_r[0]); m_b = sx16(r_d[2]);  end
            MS_R0D1: begin m_a = sx16(r_r[0]); m_b = sx16(r_d[1]);  end
            MS_R1D0: begin m_a = sx16(r_r[1]); m_b = sx16(r_d[0]);  end
            MS_SQ0:  begin m_a = r_v[0];       m_b = r_v[0];       end
            MS_SQ1:  begin m_a = r_v[1];       m_b = r_v[1];       end
            MS_SQ2:  begin m_a = r_v[2];       m_b = r_v[2];       end
            default: begin m_a = r_cosy;       m_b = r_cosp;       end
        endcase
    end

    // square root step
    logic [5:0]  sq_sh;
    logic [63:0] sq_b, sq_rb;
    assign sq_sh = 6'd62 - {i_cmd.step, 1'b0};
    assign sq_b  = 64'd1 << sq_sh;
    assign sq_rb = r_sqr + sq_b;

    // divider set-up and step
    logic signed [31:0] dv_v;
    logic        [31:0] dv_mag;
    logic        [45:0] dv_num;
    logic        [31:0] dv_s, dv_t;
    logic        [15:0] dv_val;
    logic        [1:0]  dv_idx;
    always_comb begin
        dv_idx = i_cmd.sel[1:0];
        if (dv_idx > 2'd2) begin
            dv_idx = 2'd2;
        end
    end
    assign dv_v   = r_v[dv_idx];
    assign dv_mag = dv_v[31] ? 32'(-dv_v) : 32'(dv_v);
    assign dv_num = ({14'd0, dv_mag} << 14) + {16'd0, r_sqr[30:1]};
    assign dv_s   = {1'b0, r_sqr[30:0]};
    assign dv_t   = {r_rem[30:0], r_num[15]};
    assign dv_val = r_neg ? (16'd0 - r_q) : r_q;

    assign o_stat.acc_zero = (r_acc == 64'sd0);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0] <= 16'sd0;
            r_up[1] <= ONE_Q14;
            r_up[2] <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UP_X: r_up[0] <= i_cfg_data;
                CFG_UP_Y: r_up[1] <= i_cfg_data;
                CFG_UP_Z: r_up[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= 15'sd0;
            r_yaw   <= 16'd0;
        end else if (i_cmd.op == OP_ANGLE) begin
            r_pitch <= p_clamped[14:0];
            r_yaw   <= i_action ? i_yaw_angle : r_yaw + i_yaw_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ANGLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_r[k] <= 16'sd0;
                    r_u[k] <= 16'sd0;
                end
                r_degen <= 1'b0;
            end
            OP_CINIT: begin
                r_cx   <= CORDIC_GAIN;
                r_cy   <= 32'sd0;
                r_cz   <= {c_fold, 8'd0};
                r_flip <= c_flip;
            end
            OP_CSTEP: begin
                if (!r_cz[24]) begin
                    r_cx <= r_cx - c_ys;
                    r_cy <= r_cy + c_xs;
                    r_cz <= r_cz - c_at;
                end else begin
                    r_cx <= r_cx + c_ys;
                    r_cy <= r_cy - c_xs;
                    r_cz <= r_cz + c_at;
                end
            end
            OP_CSTORE: begin
                if (i_cmd.sel == CS_YAW) begin
                    r_siny <= c_yf;
                    r_cosy <= c_xf;
                end else begin
                    r_cosp <= c_xf;
                    r_d[1] <= clamp16(64'(dy_sum >>> 14));
                end
            end
            OP_MUL:     r_prod <= m_a * m_b;
            OP_ACC_LD:  r_acc  <= r_prod;
            OP_ACC_SUB: r_acc  <= r_acc - r_prod;
            OP_ACC_ADD: r_acc  <= r_acc + r_prod;
            OP_WR: begin
                case (i_cmd.sel)
                    WD_DX: r_d[0] <= clamp16((r_prod + 64'sd2199023255552) >>> 42);
                    WD_DZ: r_d[2] <= clamp16((r_prod + 64'sd2199023255552) >>> 42);
                    WD_V0: r_v[0] <= r_acc[31:0];
                    WD_V1: r_v[1] <= r_acc[31:0];
                    WD_V2: r_v[2] <= r_acc[31:0];
                    default: ;
                endcase
            end
            OP_SQ_INIT: begin
                r_sqn <= r_acc;
                r_sqr <= 64'd0;
                if (r_acc == 64'sd0) begin
                    r_degen <= 1'b1;
                end
            end
            OP_SQ_STEP: begin
                if (r_sqn >= sq_rb) begin
                    r_sqn <= r_sqn - sq_rb;
                    r_sqr <= (r_sqr >> 1) + sq_b;
                end else begin
                    r_sqr <= r_sqr >> 1;
                end
            end
            OP_DV_INIT: begin
                r_rem <= {2'd0, dv_num[45:16]};
                r_num <= dv_num[15:0];
                r_q   <= 16'd0;
                r_neg <= dv_v[31];
            end
            OP_DV_STEP: begin
                r_num <= r_num << 1;
                if (dv_t >= dv_s) begin
                    r_rem <= dv_t - dv_s;
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_rem <= dv_t;
                    r_q   <= {r_q[14:0], 1'b0};
                end
            end
            OP_DV_STORE: begin
                case (i_cmd.sel)
                    ND_R0: r_r[0] <= dv_val;
                    ND_R1: r_r[1] <= dv_val;
                    ND_R2: r_r[2] <= dv_val;
                    ND_U0: r_u[0] <= dv_val;
                    ND_U1: r_u[1] <= dv_val;
                    ND_U2: r_u[2] <= dv_val;
                    default: ;
                endcase
            end
            OP_OUT: begin
                r_o_d     <= r_d;
                r_o_r     <= r_r;
                r_o_u     <= r_u;
                r_o_pitch <= r_pitch;
                r_o_yaw   <= r_yaw;
                r_o_degen <= r_degen;
            end
            default: ;
        endcase
    end

    assign o_dir_x      = r_o_d[0];
    assign o_dir_y      = r_o_d[1];
    assign o_dir_z      = r_o_d[2];
    assign o_right_x    = r_o_r[0];
    assign o_right_y    = r_o_r[1];
    assign o_right_z    = r_o_r[2];
    assign o_cam_up_x   = r_o_u[0];
    assign o_cam_up_y   = r_o_u[1];
    assign o_cam_up_z   = r_o_u[2];
    assign o_pitch_now  = r_o_pitch;
    assign o_yaw_now    = r_o_yaw;
    assign o_degenerate = r_o_degen;

endmodule

// ===== rtl/pycb_checker.sv =====
// Port-level checks for the camera basis block, bound to its top level.
// Depends on pycb_pkg and pitch_yaw_camera_basis_unit.
module pycb_checker
    import pycb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_dir_x,
    input logic signed [15:0] o_cam_up_x,
    input logic signed [15:0] o_cam_up_y,
    input logic signed [15:0] o_cam_up_z,
    input logic signed [14:0] o_pitch_now,
    input logic               o_degenerate
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dir_x) && $stable(o_pitch_now))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item taken while busy");

    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_now <= 15'(PITCH_LIMIT_DEF)) && (o_pitch_now >= -15'(PITCH_LIMIT_DEF)))
        else $error("pitch outside limit");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_cam_up_x == 16'sd0 && o_cam_up_y == 16'sd0
            && o_cam_up_z == 16'sd0)
        else $error("degenerate result with non-zero up");

endmodule

bind pitch_yaw_camera_basis_unit pycb_checker u_chk (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for pitch_yaw_camera_basis_unit: directed table then random items,
// each result checked against an in-bench model of the camera basis maths.
// Depends on pycb_pkg and the RTL of the block only.
module tb
    import pycb_pkg::*;
();

    typedef struct {
        logic               action;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        bit                 pin;
        logic signed [14:0] pin_pitch;
        logic signed [15:0] pin_yaw;
    } t_item;

    typedef struct {
        logic [8:0][15:0]   vec;
        logic signed [14:0] pitch_now;
        logic signed [15:0] yaw_now;
        logic               degen;
        bit                 pin;
        logic signed [14:0] pin_pitch;
        logic signed [15:0] pin_yaw;
    } t_basis;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_action;
    logic signed [15:0] i_pitch_angle;
    logic signed [15:0] i_yaw_angle;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_dir_x, o_dir_y, o_dir_z;
    logic signed [15:0] o_right_x, o_right_y, o_right_z;
    logic signed [15:0] o_cam_up_x, o_cam_up_y, o_cam_up_z;
    logic signed [14:0] o_pitch_now;
    logic signed [15:0] o_yaw_now;
    logic               o_degenerate;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    pitch_yaw_camera_basis_unit DUT (.*);

    t_item  pending_q[$];
    t_basis basis_q[$];
    t_item  dir_tab [17];

    // model state
    int          pitch_st = 0;
    logic [15:0] yaw_st = '0;
    longint      up_x = 0, up_y = 16384, up_z = 0;

    int  err_cnt = 0;
    int  snd_idle;
    int  rcv_stall;
    bit  hold_go;
    logic hold_on;
    longint cyc;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint atan_q8(int i);
        case (i)
            0: return 2097152;   1: return 1238021;   2: return 654136;
            3: return 332050;    4: return 166669;    5: return 83416;
            6: return 41718;     7: return 20860;     8: return 10430;
            9: return 5215;      10: return 2608;     11: return 1304;
            12: return 652;      13: return 326;      14: return 163;
            15: return 81;       default: return 41;
        endcase
    endfunction

    // sine and cosine of a binary angle, both Q2.28
    task automatic sincos(input int a_in, output longint s, output longint c);
        int     a;
        bit     flip;
        longint x, y, z, nx;
        a = a_in;
        flip = 0;
        if (a > 16384) begin
            a = a - 32768;
            flip = 1;
        end else if (a < -16384) begin
            a = a + 32768;
            flip = 1;
        end
        x = 163008219;
        y = 0;
        z = longint'(a) * 256;
        for (int i = 0; i < 17; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_q8(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_q8(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint scale_q14(longint v, longint unsigned s);
        longint unsigned mag, q;
        mag = longint'(v < 0 ? -v : v) * 64'd16384;
        q = (mag + s / 2) / s;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic unit_vec(input longint a, b, c, output longint oa, ob, oc,
                            output bit ok);
        longint unsigned n2, s;
        n2 = longint'(a * a) + longint'(b * b) + longint'(c * c);
        if (n2 == 0) begin
            oa = 0; ob = 0; oc = 0; ok = 0;
        end else begin
            s  = int_sqrt(n2);
            oa = scale_q14(a, s);
            ob = scale_q14(b, s);
            oc = scale_q14(c, s);
            ok = 1;
        end
    endtask

    function automatic longint sat_q14(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // advance the camera angles by one item and derive its basis
    task automatic camera_step(input t_item it, output t_basis res);
        int     p;
        longint sp, cp, sy, cy;
        longint dx, dy, dz, cx, cyy, cz, rx, ry, rz, ux, uy, uz;
        bit     ok;
        if (it.action) begin
            p = it.pitch;
            yaw_st = it.yaw;
        end else begin
            p = pitch_st + int'(it.pitch);
            yaw_st = yaw_st + it.yaw;
        end
        if (p > PITCH_LIMIT_DEF) p = PITCH_LIMIT_DEF;
        if (p < -PITCH_LIMIT_DEF) p = -PITCH_LIMIT_DEF;
        pitch_st = p;
        sincos(pitch_st, sp, cp);
        sincos(int'($signed(yaw_st)), sy, cy);
        dx = sat_q14((cy * cp + (64'sd1 <<< 41)) >>> 42);
        dy = sat_q14((sp + 8192) >>> 14);
        dz = sat_q14((sy * cp + (64'sd1 <<< 41)) >>> 42);
        cx  = dy * up_z - dz * up_y;
        cyy = dz * up_x - dx * up_z;
        cz  = dx * up_y - dy * up_x;
        unit_vec(cx, cyy, cz, rx, ry, rz, ok);
        if (ok) begin
            cx  = ry * dz - rz * dy;
            cyy = rz * dx - rx * dz;
            cz  = rx * dy - ry * dx;
            unit_vec(cx, cyy, cz, ux, uy, uz, ok);
        end else begin
            ux = 0; uy = 0; uz = 0;
        end
        res.vec[0] = dx[15:0];  res.vec[1] = dy[15:0];  res.vec[2] = dz[15:0];
        res.vec[3] = rx[15:0];  res.vec[4] = ry[15:0];  res.vec[5] = rz[15:0];
        res.vec[6] = ux[15:0];  res.vec[7] = uy[15:0];  res.vec[8] = uz[15:0];
        res.pitch_now = pitch_st[14:0];
        res.yaw_now   = yaw_st;
        res.degen     = !ok;
        res.pin       = it.pin;
        res.pin_pitch = it.pin_pitch;
        res.pin_yaw   = it.pin_yaw;
    endtask

    // sender: offer the head item, take it into the model when accepted
    always @(posedge i_clk) begin
        t_item  nxt;
        t_basis res;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_action      <= 1'b0;
            i_pitch_angle <= '0;
            i_yaw_angle   <= '0;
        end else begin
            if (i_valid && o_ready) begin
                nxt = pending_q.pop_front();
                camera_step(nxt, res);
                basis_q.push_back(res);
            end
            if (!i_valid || o_ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
                    nxt = pending_q[0];
                    i_valid       <= 1'b1;
                    i_action      <= nxt.action;
                    i_pitch_angle <= nxt.pitch;
                    i_yaw_angle   <= nxt.yaw;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // configuration writes land in the model as they are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_UP_X: up_x = longint'($signed(i_cfg_data));
                CFG_UP_Y: up_y = longint'($signed(i_cfg_data));
                CFG_UP_Z: up_z = longint'($signed(i_cfg_data));
                default: ;
            endcase
        end
    end

    // receiver: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_basis exp_b;
        bit     bad;
        logic [8:0][15:0] got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_cam_up_z, o_cam_up_y, o_cam_up_x, o_right_z, o_right_y,
                       o_right_x, o_dir_z, o_dir_y, o_dir_x};
                if (basis_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("result with nothing expected");
                end else begin
                    exp_b = basis_q.pop_front();
                    bad = (got !== exp_b.vec) || (o_pitch_now !== exp_b.pitch_now)
                        || (o_yaw_now !== exp_b.yaw_now) || (o_degenerate !== exp_b.degen);
                    if (exp_b.pin)
                        bad = bad || (o_pitch_now !== exp_b.pin_pitch)
                            || (o_yaw_now !== exp_b.pin_yaw);
                    if (bad) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("mismatch: exp vec %h pitch %0d yaw %0d degen %0d",
                                     exp_b.vec, exp_b.pitch_now, exp_b.yaw_now, exp_b.degen);
                            $display("          got vec %h pitch %0d yaw %0d degen %0d",
                                     got, o_pitch_now, o_yaw_now, o_degenerate);
                        end
                    end
                end
            end
            i_ready <= hold_on ? 1'b0 : ($urandom_range(0, 99) >= rcv_stall);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > 3000000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic add_item(logic act, logic signed [15:0] p, logic signed [15:0] y,
                            bit pin = 0, logic signed [14:0] pp = 0,
                            logic signed [15:0] py = 0);
        t_item it;
        it.action = act; it.pitch = p; it.yaw = y;
        it.pin = pin; it.pin_pitch = pp; it.pin_yaw = py;
        pending_q.push_back(it);
    endtask

    task automatic add_random(int n);
        logic signed [15:0] p, y;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                p = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) - 16'sd2000
                                         : 16'($urandom);
                y = $urandom_range(0, 1) ? 16'($urandom_range(0, 8000)) - 16'sd4000
                                         : 16'($urandom);
                add_item(1'b0, p, y);
            end else begin
                add_item(1'b1, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_up(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        write_reg(CFG_UP_X, x);
        write_reg(CFG_UP_Y, y);
        write_reg(CFG_UP_Z, z);
    endtask

    task automatic drain;
        @(posedge i_clk);
        while (pending_q.size() != 0 || basis_q.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        snd_idle = 0;
        rcv_stall = 0;
        hold_go = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, default world up: action, pitch, yaw, pinned, pitch, yaw
        dir_tab = '{
            '{1'b0, 16'sd0,      16'sd0,      1'b1, 15'sd0,      16'sd0},
            '{1'b1, 16'sd32767,  16'sd0,      1'b1, 15'sd16194,  16'sd0},
            '{1'b0, 16'sd16000,  16'sd0,      1'b1, 15'sd16194,  16'sd0},
            '{1'b1, -16'sd32768, 16'sd0,      1'b1, -15'sd16194, 16'sd0},
            '{1'b0, -16'sd32768, 16'sd0,      1'b1, -15'sd16194, 16'sd0},
            '{1'b1, 16'sd16194,  16'sd32767,  1'b1, 15'sd16194,  16'sd32767},
            '{1'b0, 16'sd1,      16'sd1,      1'b1, 15'sd16194,  -16'sd32768},
            '{1'b1, -16'sd16194, -16'sd32768, 1'b1, -15'sd16194, -16'sd32768},
            '{1'b0, 16'sd0,      -16'sd1,     1'b1, -15'sd16194, 16'sd32767},
            '{1'b1, 16'sd0,      16'sd16384,  1'b0, 15'sd0,      16'sd0},
            '{1'b1, 16'sd0,      -16'sd16384, 1'b0, 15'sd0,      16'sd0},
            '{1'b1, 16'sd8192,   16'sd16385,  1'b0, 15'sd0,      16'sd0},
            '{1'b1, -16'sd8192,  -16'sd16385, 1'b0, 15'sd0,      16'sd0},
            '{1'b1, 16'sd16193,  16'sd0,      1'b0, 15'sd0,      16'sd0},
            '{1'b0, 16'sd32767,  16'sd32767,  1'b0, 15'sd0,      16'sd0},
            '{1'b0, -16'sd32768, -16'sd32768, 1'b0, 15'sd0,      16'sd0},
            '{1'b1, 16'sd0,      16'sd0,      1'b0, 15'sd0,      16'sd0}
        };
        foreach (dir_tab[k]) pending_q.push_back(dir_tab[k]);
        drain();

        // phase: no idling, with one long receiver hold-off
        snd_idle = 0; rcv_stall = 0;
        hold_go = 1;
        add_random(300);
        drain();

        // world up along x: pitch and yaw zero point straight along it
        set_up(16'sd16384, 16'sd0, 16'sd0);
        write_reg(2'd3, 16'h1234);
        add_item(1'b1, 16'sd0, 16'sd0);
        add_item(1'b1, 16'sd0, -16'sd32768);
        snd_idle = 69; rcv_stall = 0;
        add_random(300);
        drain();

        // world up zero: every item is degenerate
        set_up(16'sd0, 16'sd0, 16'sd0);
        add_item(1'b1, 16'sd0, 16'sd0, 1, 15'sd0, 16'sd0);
        add_item(1'b0, 16'sd100, 16'sd100);
        snd_idle = 0; rcv_stall = 69;
        add_random(60);
        drain();

        // extremes of world up: negative x and y, positive z
        set_up(-16'sd16384, -16'sd16384, 16'sd16384);
        snd_idle = 17; rcv_stall = 17;
        add_random(300);
        drain();

        // register values beyond unit range are used as written
        set_up(16'sh7FFF, 16'sh8000, 16'sd5);
        snd_idle = 69; rcv_stall = 69;
        add_random(250);
        drain();

        set_up(16'($urandom), 16'($urandom), 16'($urandom));
        snd_idle = 0; rcv_stall = 69;
        add_random(200);
        drain();

        set_up(16'($urandom_range(0, 32768)) - 16'sd16384,
               16'($urandom_range(0, 32768)) - 16'sd16384,
               16'($urandom_range(0, 32768)) - 16'sd16384);
        snd_idle = 69; rcv_stall = 0;
        add_random(200);
        drain();

        set_up(16'sd0, -16'sd16384, 16'sd0);
        snd_idle = 0; rcv_stall = 0;
        add_random(200);
        drain();

        repeat (300) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
